### design/plls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plls_pkg
// Shared types, widths and log tables for the Poisson log-likelihood summer.
// ----------------------------------------------------------------------------
package plls_pkg;

   localparam int VALUE_W    = 56;
   localparam int SUM_W      = 64;
   localparam int FLOOR_W    = 33;
   localparam int TAB_BITS   = 10;
   localparam int TAB_SIZE   = 1 << TAB_BITS;
   localparam int NORM_STEPS = 6;
   localparam int MUL_STEPS  = 4;

   localparam logic [FLOOR_W-1:0] FLOOR_RESET = 33'd4;
   localparam logic [31:0]        LN2_Q32     = 32'd2977044472;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM,
      ST_LOOKUP,
      ST_DIFF,
      ST_SQUARE,
      ST_CUBE,
      ST_LOG,
      ST_MUL,
      ST_TERM,
      ST_ACCUM
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       ready;
      logic       load;
      logic       norm;
      logic [2:0] norm_step;
      logic       lookup;
      logic       diff;
      logic       square;
      logic       cube;
      logic       log_en;
      logic       mul;
      logic [1:0] mul_step;
      logic       term;
      logic       accum;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;
      logic out_free;
   } status_type;

   typedef logic [32:0] tab_type [TAB_SIZE];

   // 2^(32+TAB_BITS) / (TAB_SIZE + i) by restoring long division
   function automatic logic [63:0] recip_entry(int i);
      logic [63:0] divisor;
      logic [63:0] rem;
      logic [63:0] quo;
      divisor = 64'(TAB_SIZE) + 64'(i);
      rem     = '0;
      quo     = '0;
      for (int b = 32 + TAB_BITS; b >= 0; b--) begin
         rem = {rem[62:0], (b == 32 + TAB_BITS)};
         if (rem >= divisor) begin
            rem    = rem - divisor;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // reciprocal table, Q.32
   function automatic tab_type build_recip();
      tab_type t;
      for (int i = 0; i < TAB_SIZE; i++) begin
         t[i] = 33'(recip_entry(i));
      end
      return t;
   endfunction

   // ln(2^32 / r) in Q.32 through a squaring recurrence on log2
   function automatic tab_type build_lnr();
      tab_type     t;
      logic [63:0] r;
      logic [63:0] z;
      logic [63:0] f;
      logic [63:0] p;
      for (int i = 0; i < TAB_SIZE; i++) begin
         r = recip_entry(i);
         if (r >= 64'h1_0000_0000) begin
            t[i] = '0;
         end else begin
            z = r;
            f = '0;
            for (int k = 0; k < 32; k++) begin
               z = (z * z) >> 31;
               if (z >= 64'h1_0000_0000) begin
                  z = z >> 1;
                  f = f | (64'd1 << (31 - k));
               end
            end
            p = (64'h1_0000_0000 - f) * {32'd0, LN2_Q32};
            t[i] = 33'((p + 64'h8000_0000) >> 32);
         end
      end
      return t;
   endfunction

   localparam tab_type RECIP_TAB = build_recip();
   localparam tab_type LNR_TAB   = build_lnr();

endpackage

### design/plls_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plls_req_if / plls_rsp_if
// Valid/ready channels for input elements and summed results.
// ----------------------------------------------------------------------------
interface plls_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [plls_pkg::VALUE_W-1:0]  simulated_rate;
   logic signed [plls_pkg::VALUE_W-1:0]  observed_count;
   logic                                 last_element;

   modport source (output valid, simulated_rate, observed_count, last_element,
                   input ready);
   modport sink   (input valid, simulated_rate, observed_count, last_element,
                   output ready);
endinterface

interface plls_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [plls_pkg::SUM_W-1:0]  likelihood_sum;
   logic                               sum_valid;

   modport source (output valid, likelihood_sum, sum_valid, input ready);
   modport sink   (input valid, likelihood_sum, sum_valid, output ready);
endinterface

### design/poisson_log_likelihood_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poisson_log_likelihood_sum
// Sums y*ln(s) - s over a stream of elements into a saturating Q40.24 total.
// ----------------------------------------------------------------------------
// usage:
//   req_chan carries one element per word: simulated_rate and observed_count
//   (signed Q24.32) and last_element. rsp_chan returns one word per element
//   marked last: the saturated sum and sum_valid (0 when any saturation hit).
//   csr_wr_en/csr_wr_data set the rate floor (Q.32, 0 acts as 1); write it
//   only while the block is idle.
// timing:
//   the single sequencer takes one element at a time through: accept, six
//   leading-one search steps, table lookup, the log series (difference,
//   square, cube, log), four partial products of the split 56x64 multiply,
//   then term and accumulate. a result appears in the result register on
//   the cycle after the last element's accumulate.
// reset:
//   synchronous, clears the sum, the overflow flag and the result valid flag
//   and sets the floor to 4.
// stall:
//   a finished result waits in its register; the next elements are still
//   taken, and only a later final element waits for the register to free.
// ----------------------------------------------------------------------------
module poisson_log_likelihood_sum (
   input  logic        clock,
   input  logic        reset,
   plls_req_if.sink    req_chan,
   plls_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [32:0] csr_wr_data
);

   plls_pkg::cmd_type    cmd;
   plls_pkg::status_type status;

   // sequencer
   plls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic
   plls_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

### design/plls_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plls_ctrl
// Sequencer that steps one word through the log, multiply and accumulate.
// ----------------------------------------------------------------------------
module plls_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  plls_pkg::status_type   status,
   output plls_pkg::cmd_type      cmd
);

   plls_pkg::state_type state_ff, state_in;
   logic [2:0]          norm_cnt_ff, norm_cnt_in;
   logic [1:0]          mul_cnt_ff, mul_cnt_in;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= plls_pkg::ST_IDLE;
         norm_cnt_ff <= '0;
         mul_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         norm_cnt_ff <= norm_cnt_in;
         mul_cnt_ff  <= mul_cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      norm_cnt_in   = norm_cnt_ff;
      mul_cnt_in    = mul_cnt_ff;
      cmd           = '0;
      cmd.norm_step = norm_cnt_ff;
      cmd.mul_step  = mul_cnt_ff;
      case (state_ff)
         plls_pkg::ST_IDLE: begin
            cmd.ready = 1'b1;
            if (req_valid) begin
               cmd.load    = 1'b1;
               norm_cnt_in = '0;
               state_in    = plls_pkg::ST_NORM;
            end
         end
         plls_pkg::ST_NORM: begin
            cmd.norm = 1'b1;
            if (norm_cnt_ff == 3'(plls_pkg::NORM_STEPS - 1)) begin
               state_in = plls_pkg::ST_LOOKUP;
            end else begin
               norm_cnt_in = norm_cnt_ff + 3'd1;
            end
         end
         plls_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = plls_pkg::ST_DIFF;
         end
         plls_pkg::ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = plls_pkg::ST_SQUARE;
         end
         plls_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = plls_pkg::ST_CUBE;
         end
         plls_pkg::ST_CUBE: begin
            cmd.cube = 1'b1;
            state_in = plls_pkg::ST_LOG;
         end
         plls_pkg::ST_LOG: begin
            cmd.log_en = 1'b1;
            mul_cnt_in = '0;
            state_in   = plls_pkg::ST_MUL;
         end
         plls_pkg::ST_MUL: begin
            cmd.mul    = 1'b1;
            mul_cnt_in = mul_cnt_ff + 2'd1;
            if (mul_cnt_ff == 2'(plls_pkg::MUL_STEPS - 1)) begin
               state_in = plls_pkg::ST_TERM;
            end
         end
         plls_pkg::ST_TERM: begin
            cmd.term = 1'b1;
            state_in = plls_pkg::ST_ACCUM;
         end
         plls_pkg::ST_ACCUM: begin
            // a final word waits for the result register to free up
            if (!status.last || status.out_free) begin
               cmd.accum = 1'b1;
               state_in  = plls_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plls_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### design/plls_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plls_datapath
// Clamp, fixed-point ln, split multiply and saturating accumulate.
// ----------------------------------------------------------------------------
module plls_datapath (
   input  logic                   clock,
   input  logic                   reset,
   plls_req_if.sink               req_chan,
   plls_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [32:0]            csr_wr_data,
   input  plls_pkg::cmd_type      cmd,
   output plls_pkg::status_type   status
);

   localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

   logic [32:0]         rate_floor_ff;
   logic [55:0]         sim_ff, obs_ff;
   logic                last_ff;
   logic [63:0]         x_ff;
   logic [5:0]          lz_ff;
   logic [63:0]         y_ff;
   logic [32:0]         lnr_ff;
   logic signed [25:0]  d_ff;
   logic signed [19:0]  d2_ff;
   logic signed [43:0]  base_ff;
   logic signed [13:0]  d3_ff;
   logic                neg_ff;
   logic [63:0]         b_ff;
   logic [127:0]        acc_ff;
   logic signed [63:0]  term_ff;
   logic                ovf_ff;
   logic signed [63:0]  sum_ff;
   logic                seen_ff;
   logic                rsp_valid_ff;
   logic signed [63:0]  rsp_sum_ff;
   logic                rsp_ok_ff;

   // clamps
   logic [32:0]         floor_eff;
   logic                sim_low;
   logic [55:0]         sim_clamp, obs_clamp;

   assign floor_eff = (rate_floor_ff == '0) ? 33'd1 : rate_floor_ff;
   assign sim_low   = req_chan.simulated_rate < $signed({1'b0, floor_eff});
   assign sim_clamp = sim_low ? 56'(floor_eff) : req_chan.simulated_rate;
   assign obs_clamp = req_chan.observed_count[55] ? '0 : req_chan.observed_count;

   // leading-one search step
   logic [5:0]  norm_amt;
   logic [63:0] norm_mask;
   logic        norm_zero;

   assign norm_amt  = 6'd32 >> cmd.norm_step;
   assign norm_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> norm_amt);
   assign norm_zero = (x_ff & norm_mask) == '0;

   // reciprocal lookup and mantissa product
   logic [plls_pkg::TAB_BITS-1:0] idx;
   logic [63:0]                   y_prod;

   assign idx    = x_ff[62 -: plls_pkg::TAB_BITS];
   assign y_prod = {33'd0, x_ff[63:33]} * {31'd0, plls_pkg::RECIP_TAB[idx]};

   // series residual
   logic [63:0]         y_diff;
   logic signed [51:0]  sq_prod;
   logic signed [45:0]  cube_prod;
   logic signed [6:0]   expo;
   logic signed [43:0]  base_prod;

   assign y_diff    = y_ff - 64'h4000_0000_0000_0000;
   assign sq_prod   = 52'(d_ff) * 52'(d_ff);
   assign cube_prod = 46'(d2_ff) * 46'(d_ff);
   assign expo      = 7'sd31 - $signed({1'b0, lz_ff});
   assign base_prod = 44'(expo) * $signed(44'(plls_pkg::LN2_Q32))
                      + $signed(44'(lnr_ff));

   // d3 / 3, truncated toward zero
   logic [13:0]         d3_mag;
   logic [31:0]         q3_prod;
   logic signed [15:0]  q3;
   logic signed [63:0]  ln_val;

   assign d3_mag  = d3_ff[13] ? 14'(-d3_ff) : 14'(d3_ff);
   assign q3_prod = 32'(d3_mag) * 32'd43691;
   assign q3      = d3_ff[13] ? -$signed({1'b0, q3_prod[31:17]})
                              : $signed({1'b0, q3_prod[31:17]});
   assign ln_val  = 64'(base_ff) + 64'(d_ff) - 64'(d2_ff >>> 1) + 64'(q3);

   // partial product of the split multiply
   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [127:0] pp_shift;

   assign a_half = cmd.mul_step[1] ? {8'd0, obs_ff[55:32]} : obs_ff[31:0];
   assign b_half = cmd.mul_step[0] ? b_ff[63:32] : b_ff[31:0];
   assign pp     = 64'(a_half) * 64'(b_half);

   always_comb begin
      case (cmd.mul_step)
         2'd0:    pp_shift = {64'd0, pp};
         2'd3:    pp_shift = {pp, 64'd0};
         default: pp_shift = {32'd0, pp, 32'd0};
      endcase
   end

   // product saturation and term
   logic [23:0]         p_hi;
   logic [63:0]         p_lo;
   logic signed [63:0]  prod;
   logic                prod_ovf;
   logic [63:0]         simq;
   logic [64:0]         term_wide;
   logic                term_ovf;

   assign p_hi = acc_ff[127:104];
   assign p_lo = acc_ff[103:40];

   always_comb begin
      prod_ovf = 1'b0;
      if (!neg_ff) begin
         if (p_hi != '0 || p_lo[63]) begin
            prod_ovf = 1'b1;
            prod     = MAX64;
         end else begin
            prod = $signed(p_lo);
         end
      end else begin
         if (p_hi != '0 || p_lo > 64'h8000_0000_0000_0000) begin
            prod_ovf = 1'b1;
            prod     = MIN64;
         end else begin
            prod = $signed(-p_lo);
         end
      end
   end

   assign simq      = {8'd0, sim_ff} >> 8;
   assign term_wide = {prod[63], prod} - {1'b0, simq};
   assign term_ovf  = term_wide[64] != term_wide[63];

   // accumulator
   logic [64:0]         sum_wide;
   logic                sum_ovf;
   logic signed [63:0]  sum_sat;

   assign sum_wide = {sum_ff[63], sum_ff} + {term_ff[63], term_ff};
   assign sum_ovf  = sum_wide[64] != sum_wide[63];
   assign sum_sat  = sum_ovf ? (sum_wide[64] ? MIN64 : MAX64) : $signed(sum_wide[63:0]);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_floor_ff <= plls_pkg::FLOOR_RESET;
         sum_ff        <= '0;
         seen_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            rate_floor_ff <= csr_wr_data;
         end
         if (cmd.accum) begin
            if (last_ff) begin
               sum_ff  <= '0;
               seen_ff <= 1'b0;
            end else begin
               sum_ff  <= sum_sat;
               seen_ff <= seen_ff | ovf_ff | sum_ovf;
            end
         end
         if (cmd.accum && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sim_ff  <= sim_clamp;
         obs_ff  <= obs_clamp;
         last_ff <= req_chan.last_element;
         x_ff    <= {8'd0, sim_clamp};
         lz_ff   <= '0;
      end
      if (cmd.norm && norm_zero) begin
         x_ff  <= x_ff << norm_amt;
         lz_ff <= lz_ff + norm_amt;
      end
      if (cmd.lookup) begin
         y_ff   <= y_prod;
         lnr_ff <= plls_pkg::LNR_TAB[idx];
      end
      if (cmd.diff) begin
         d_ff <= $signed(y_diff[55:30]);
      end
      if (cmd.square) begin
         d2_ff   <= sq_prod[51:32];
         base_ff <= base_prod;
      end
      if (cmd.cube) begin
         d3_ff <= cube_prod[45:32];
      end
      if (cmd.log_en) begin
         neg_ff <= ln_val[63];
         b_ff   <= ln_val[63] ? 64'(-ln_val) : 64'(ln_val);
         acc_ff <= '0;
      end
      if (cmd.mul) begin
         acc_ff <= acc_ff + pp_shift;
      end
      if (cmd.term) begin
         term_ff <= term_ovf ? MIN64 : $signed(term_wide[63:0]);
         ovf_ff  <= prod_ovf | term_ovf;
      end
      if (cmd.accum && last_ff) begin
         rsp_sum_ff <= sum_sat;
         rsp_ok_ff  <= !(seen_ff | ovf_ff | sum_ovf);
      end
   end

   assign req_chan.ready          = cmd.ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.likelihood_sum = rsp_sum_ff;
   assign rsp_chan.sum_valid      = rsp_ok_ff;

   assign status.last     = last_ff;
   assign status.out_free = !rsp_valid_ff || rsp_chan.ready;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives element words into the Poisson log-likelihood summer under random
// idling on both channels, predicts every summed result in fixed point and
// checks each returned word field by field, over several rate floor values.
// ----------------------------------------------------------------------------
module testbench;

   // ------------------------------------------------------------------------
   // result predictor and store of expected sums
   // ------------------------------------------------------------------------
   class likelihood_scoreboard;
      logic [32:0]        rate_floor;
      logic signed [63:0] sum_acc;
      bit                 sat_seen;
      logic signed [63:0] exp_sum [$];
      bit                 exp_ok [$];
      int                 fails;
      int                 results;

      function void clear();
         rate_floor = plls_pkg::FLOOR_RESET;
         sum_acc = 0;
         sat_seen = 0;
         fails = 0;
         results = 0;
      endfunction

      // floor shift of a signed value
      static function logic signed [63:0] asr(logic signed [63:0] x, int s);
         return x >>> s;
      endfunction

      // natural log of s / 2^32, s >= 1, result Q.32
      function logic signed [63:0] ln_q32(logic signed [63:0] s);
         logic [63:0]        u;
         logic [63:0]        m;
         logic [63:0]        y;
         logic signed [63:0] d;
         logic signed [63:0] d2;
         logic signed [63:0] d3;
         logic signed [63:0] lny;
         int                 p;
         int                 idx;
         u = s;
         p = 63;
         while (p > 0 && !u[p]) p--;
         m = (p >= 30) ? (u >> (p - 30)) : (u << (30 - p));
         idx = int'((m >> (30 - plls_pkg::TAB_BITS)) & 64'(plls_pkg::TAB_SIZE - 1));
         y = m * 64'(plls_pkg::RECIP_TAB[idx]);
         d = asr($signed(y - (64'd1 << 62)), 30);
         d2 = asr(d * d, 32);
         d3 = asr(d2 * d, 32);
         lny = d - asr(d2, 1) + d3 / 3;
         return (64'(p) - 64'sd32) * $signed({32'd0, plls_pkg::LN2_Q32})
                + $signed({31'd0, plls_pkg::LNR_TAB[idx]}) + lny;
      endfunction

      function logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b,
                                           ref bit ovf);
         logic signed [64:0] r;
         r = 65'(a) + 65'(b);
         if (r > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
            ovf = 1;
            return 64'sh7FFF_FFFF_FFFF_FFFF;
         end
         if (r < -65'sh0_8000_0000_0000_0000) begin
            ovf = 1;
            return 64'sh8000_0000_0000_0000;
         end
         return r[63:0];
      endfunction

      // notes one accepted element, queues a sum on the last one
      function void note_element(logic signed [55:0] sim_in, logic signed [55:0] obs_in,
                                 bit last);
         logic signed [63:0]  sim;
         logic signed [63:0]  obs;
         logic signed [63:0]  fl;
         logic signed [63:0]  lnv;
         logic [63:0]         mag;
         logic [127:0]        prod_w;
         logic signed [63:0]  prod;
         logic signed [63:0]  term;
         bit                  ovf;
         ovf = 0;
         sim = 64'(sim_in);
         obs = 64'(obs_in);
         if (obs < 0) obs = 0;
         fl = (rate_floor == 0) ? 64'sd1 : $signed({31'd0, rate_floor});
         if (sim < fl) sim = fl;
         lnv = ln_q32(sim);
         mag = (lnv < 0) ? 64'(-lnv) : 64'(lnv);
         prod_w = (128'(obs) * 128'(mag)) >> 40;
         if (lnv >= 0) begin
            if (prod_w > 128'h7FFF_FFFF_FFFF_FFFF) begin
               ovf = 1;
               prod = 64'sh7FFF_FFFF_FFFF_FFFF;
            end else prod = prod_w[63:0];
         end else begin
            if (prod_w > 128'h8000_0000_0000_0000) begin
               ovf = 1;
               prod = 64'sh8000_0000_0000_0000;
            end else prod = -$signed(prod_w[63:0]);
         end
         term = sat_add(prod, -(sim >>> 8), ovf);
         sum_acc = sat_add(sum_acc, term, ovf);
         if (ovf) sat_seen = 1;
         if (last) begin
            exp_sum.push_back(sum_acc);
            exp_ok.push_back(!sat_seen);
            sum_acc = 0;
            sat_seen = 0;
         end
      endfunction

      // compares one returned word with the oldest expected sum
      function void check_sum(logic signed [63:0] got_sum, logic got_ok);
         logic signed [63:0] want_sum;
         bit                 want_ok;
         results++;
         if (exp_sum.size() == 0) begin
            $display("%0t: unexpected result sum %0d valid %0b", $time, got_sum, got_ok);
            fails++;
            return;
         end
         want_sum = exp_sum.pop_front();
         want_ok = exp_ok.pop_front();
         if (got_sum !== want_sum) begin
            $display("%0t: likelihood_sum expected %0d actual %0d", $time, want_sum, got_sum);
            fails++;
         end
         if (got_ok !== want_ok) begin
            $display("%0t: sum_valid expected %0b actual %0b", $time, want_ok, got_ok);
            fails++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [32:0] csr_wr_data;
   int          send_idle;
   int          recv_idle;
   int          words_sent;

   plls_req_if req_chan ();
   plls_rsp_if rsp_chan ();

   likelihood_scoreboard sb;

   poisson_log_likelihood_sum uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #60ms;
      $display("simulation failed");
      $finish;
   end

   // receiver with random stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_sum(rsp_chan.likelihood_sum, rsp_chan.sum_valid);
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // one element word, with random idling before it; valid stays up after
   // the accept so that words can follow back to back
   task automatic send_word(logic signed [55:0] sim, logic signed [55:0] obs, bit last);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.simulated_rate <= sim;
      req_chan.observed_count <= obs;
      req_chan.last_element <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_element(sim, obs, last);
      words_sent++;
   endtask

   // drop valid, wait for every expected sum, then let the pipeline drain
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sb.exp_sum.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_floor(logic [32:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.rate_floor = v;
   endtask

   // random value: mostly realistic magnitudes, some extremes
   function automatic logic signed [55:0] rand_value();
      logic signed [55:0] v;
      case ($urandom_range(9))
         0: v = 56'({$urandom, $urandom});
         1: v = 56'($urandom_range(15));
         2: v = -$signed(56'($urandom_range(1000)));
         3: v = {$urandom_range(1) ? 56'h7F_FFFF_FFFF_FFFF : 56'h80_0000_0000_0000};
         default: v = 56'({$urandom_range(4095), $urandom});
      endcase
      return v;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++)
         send_word(rand_value(), rand_value(), $urandom_range(7) == 0);
      send_word(rand_value(), rand_value(), 1);
   endtask

   initial begin
      logic signed [55:0] edge_vals [8];
      sb = new();
      sb.clear();
      words_sent = 0;
      send_idle = 22;
      recv_idle = 53;
      reset = 1;
      csr_wr_en = 0;
      csr_wr_data = '0;
      req_chan.valid = 0;
      req_chan.simulated_rate = '0;
      req_chan.observed_count = '0;
      req_chan.last_element = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, negatives, floors, one-element sums, overflow
      edge_vals = '{56'sh7F_FFFF_FFFF_FFFF, 56'sh80_0000_0000_0000, 0, 1, -1,
                    56'sh1_0000_0000, 56'sh3, 56'sh55_5555_AAAA_AAAA};
      for (int i = 0; i < 8; i++)
         send_word(edge_vals[i], edge_vals[7 - i], (i % 2) == 1);
      send_word(56'sh7F_FFFF_FFFF_FFFF, 0, 0);
      send_word(56'sh7F_FFFF_FFFF_FFFF, 0, 1);
      send_word(1, 56'sh7F_FFFF_FFFF_FFFF, 1);
      send_word(56'sh2_0000_0000, 56'sh7F_FFFF_FFFF_FFFF, 1);
      drain();
      write_floor('0);
      send_word(0, 56'sh1_0000_0000, 1);
      send_word(-5, 56'sh7F_FFFF_FFFF_FFFF, 1);
      drain();
      write_floor(33'h1_0000_0000);
      send_word(56'sh8000_0000, 56'sh3_0000_0000, 1);
      send_word(56'sh7F_FFFF_FFFF_FFFF, 56'sh7F_FFFF_FFFF_FFFF, 1);
      drain();

      // random phases across idle profiles and floor settings
      write_floor(33'd1);
      random_phase(380);
      drain();
      send_idle = 53;
      recv_idle = 22;
      write_floor(33'h1_FFFF_FFFF);
      random_phase(380);
      drain();
      send_idle = 0;
      recv_idle = 0;
      write_floor(33'($urandom_range(1 << 20)));
      random_phase(380);
      drain();

      $display("sent %0d element words, checked %0d sums over several rate floors",
               words_sent, sb.results);
      if (sb.fails == 0 && sb.exp_sum.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
